// ===== hdl/tidwt_pkg.sv =====
// shared types for the tile inverse wavelet core
package tidwt_pkg;

   localparam int DATA_W = 16;

   typedef logic signed [DATA_W-1:0] sample_type;
   typedef logic signed [DATA_W:0]   opnd_type;

   typedef enum logic [1:0] {
      TAIL_TWO   = 2'd0,
      TAIL_THREE = 2'd1,
      TAIL_FOUR  = 2'd2
   } tail_type;

   typedef struct packed {
      logic     start;
      logic     src_scratch;
      tail_type tail;
   } line_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } line_stat_type;

endpackage

// ===== hdl/tile_inverse_dwt_extrapolate_core.sv =====
// top level: tile stores, request handling and level/pass/line sequencer
//
//   channel  | ports                                   | direction
//   req      | req_valid req_ready req_type req_index  | in
//            | req_coeff_value                         |
//   rsp      | rsp_valid rsp_ready rsp_sample          | out
//            | rsp_done_res                            |
//
// after reset the coefficient store is zeroed; no words are taken until that is done
// write word: goes straight into the coefficient store; read word: store read register, then response register
// run word: all three levels, every line in turn on the one lifting unit with one read port
// a pending response holds off new words until it is taken
module tile_inverse_dwt_extrapolate_core import tidwt_pkg::*; #(
   parameter int TILE_SIDE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [11:0] req_index,
   input  logic signed [15:0] req_coeff_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [15:0] rsp_sample,
   output logic        rsp_done_res
);

   localparam int STORE = TILE_SIDE * TILE_SIDE;
   localparam int AW    = $clog2(STORE);
   localparam int CW    = $clog2(TILE_SIDE + 2);

   localparam int NL1 = (TILE_SIDE >> 1) + 1;
   localparam int NH1 = (TILE_SIDE >> 1) - 1;
   localparam int NL2 = (TILE_SIDE >> 2) + 1;
   localparam int NH2 = (TILE_SIDE + 2) >> 2;
   localparam int NL3 = (TILE_SIDE >> 3) + 1;
   localparam int NH3 = (TILE_SIDE + 4) >> 3;
   localparam int B1  = 0;
   localparam int B2  = B1 + 2 * NL1 * NH1 + NH1 * NH1;
   localparam int B3  = B2 + 2 * NL2 * NH2 + NH2 * NH2;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_RUN   = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [1:0] LVL_ONE   = 2'd1;
   localparam logic [1:0] LVL_TWO   = 2'd2;
   localparam logic [1:0] LVL_THREE = 2'd3;

   typedef enum logic [5:0] {
      T_CLEAR = 6'b000001,
      T_IDLE  = 6'b000010,
      T_READ  = 6'b000100,
      T_PASS  = 6'b001000,
      T_LINE  = 6'b010000,
      T_WAIT  = 6'b100000
   } tstate_type;

   typedef enum logic [1:0] {
      PASS_ROWL = 2'd0,
      PASS_ROWH = 2'd1,
      PASS_COL  = 2'd2
   } pass_type;

   tstate_type    st_ff, st_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [1:0]    lvl_ff, lvl_in;
   pass_type      pass_ff, pass_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] plo_ff, plo_in, phi_ff, phi_in, pd_ff, pd_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sample_type    rsp_sample_ff, rsp_sample_in;
   logic          rsp_done_ff, rsp_done_in;
   logic          rd_ok_ff, rd_ok_in;

   sample_type    coef_mem [STORE];
   sample_type    scr_mem  [STORE];
   sample_type    coef_rd_ff, scr_rd_ff;
   logic          coef_we, scr_we;
   logic [AW-1:0] coef_wa, coef_ra, scr_wa, scr_ra;
   sample_type    coef_wd, scr_wd;

   logic [CW-1:0] lv_nl, lv_nh, lv_w, cnt_lim;
   logic [AW-1:0] lv_b, lv_lh, lv_hh, lv_ll, lv_hrow;
   logic [AW-1:0] inc_lo, inc_hi, inc_d, stride;
   tail_type      lv_tail;

   logic          acc, in_range, is_col;
   logic [AW-1:0] req_addr;

   line_ctl_type  ctl;
   line_stat_type stat;
   logic [AW-1:0] eng_ra, eng_wa;
   logic          eng_we;
   sample_type    eng_wd, eng_rd;

   function automatic tail_type tail_of(input int nl, input int nh);
      if (nl <= nh) begin
         return TAIL_TWO;
      end else if (nl == nh + 1) begin
         return TAIL_THREE;
      end
      return TAIL_FOUR;
   endfunction

   tidwt_line #(
      .AW (AW),
      .CW (CW)
   ) u_line (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .cfg_lo     (plo_ff),
      .cfg_hi     (phi_ff),
      .cfg_d      (pd_ff),
      .cfg_stride (stride),
      .cfg_nh     (lv_nh),
      .rd_data    (eng_rd),
      .rd_addr    (eng_ra),
      .wr_en      (eng_we),
      .wr_addr    (eng_wa),
      .wr_data    (eng_wd),
      .stat       (stat)
   );

   // per level band geometry
   always_comb begin
      case (lvl_ff)
         LVL_THREE: begin
            lv_nl   = CW'(NL3);
            lv_nh   = CW'(NH3);
            lv_w    = CW'(NL3 + NH3);
            lv_b    = AW'(B3);
            lv_lh   = AW'(B3 + NH3 * NL3);
            lv_hh   = AW'(B3 + 2 * NH3 * NL3);
            lv_ll   = AW'(B3 + 2 * NH3 * NL3 + NH3 * NH3);
            lv_hrow = AW'(NL3 * (NL3 + NH3));
            lv_tail = tail_of(NL3, NH3);
         end
         LVL_TWO: begin
            lv_nl   = CW'(NL2);
            lv_nh   = CW'(NH2);
            lv_w    = CW'(NL2 + NH2);
            lv_b    = AW'(B2);
            lv_lh   = AW'(B2 + NH2 * NL2);
            lv_hh   = AW'(B2 + 2 * NH2 * NL2);
            lv_ll   = AW'(B2 + 2 * NH2 * NL2 + NH2 * NH2);
            lv_hrow = AW'(NL2 * (NL2 + NH2));
            lv_tail = tail_of(NL2, NH2);
         end
         default: begin
            lv_nl   = CW'(NL1);
            lv_nh   = CW'(NH1);
            lv_w    = CW'(NL1 + NH1);
            lv_b    = AW'(B1);
            lv_lh   = AW'(B1 + NH1 * NL1);
            lv_hh   = AW'(B1 + 2 * NH1 * NL1);
            lv_ll   = AW'(B1 + 2 * NH1 * NL1 + NH1 * NH1);
            lv_hrow = AW'(NL1 * (NL1 + NH1));
            lv_tail = tail_of(NL1, NH1);
         end
      endcase
   end

   always_comb begin
      is_col = (pass_ff == PASS_COL);
      case (pass_ff)
         PASS_ROWL: cnt_lim = lv_nl;
         PASS_ROWH: cnt_lim = lv_nh;
         default:   cnt_lim = lv_w;
      endcase
      if (is_col) begin
         inc_lo = AW'(1);
         inc_hi = AW'(1);
         inc_d  = AW'(1);
         stride = AW'(lv_w);
      end else begin
         inc_lo = AW'(lv_nl);
         inc_hi = AW'(lv_nh);
         inc_d  = AW'(lv_w);
         stride = AW'(1);
      end
      eng_rd = is_col ? scr_rd_ff : coef_rd_ff;
   end

   assign req_ready    = (st_ff == T_IDLE) && !rsp_valid_ff;
   assign acc          = req_valid && req_ready;
   assign in_range     = (32'(req_index) < STORE);
   assign req_addr     = AW'(req_index);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sample   = rsp_sample_ff;
   assign rsp_done_res = rsp_done_ff;

   always_comb begin
      st_in = st_ff;
      clr_in = clr_ff;
      lvl_in = lvl_ff;
      pass_in = pass_ff;
      cnt_in = cnt_ff;
      plo_in = plo_ff;
      phi_in = phi_ff;
      pd_in = pd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_done_in = rsp_done_ff;
      rd_ok_in = rd_ok_ff;
      ctl.start = 1'b0;
      ctl.src_scratch = is_col;
      ctl.tail = lv_tail;

      coef_we = 1'b0;
      coef_wa = eng_wa;
      coef_wd = eng_wd;
      coef_ra = (st_ff == T_IDLE) ? req_addr : eng_ra;
      scr_we  = 1'b0;
      scr_wa  = eng_wa;
      scr_wd  = eng_wd;
      scr_ra  = eng_ra;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (st_ff)
         T_CLEAR: begin
            coef_we = 1'b1;
            coef_wa = clr_ff;
            coef_wd = '0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(STORE - 1)) begin
               st_in = T_IDLE;
            end
         end
         T_IDLE: begin
            if (acc) begin
               case (req_type)
                  REQ_WRITE: begin
                     coef_we = in_range;
                     coef_wa = req_addr;
                     coef_wd = req_coeff_value;
                  end
                  REQ_RUN: begin
                     lvl_in = LVL_THREE;
                     pass_in = PASS_ROWL;
                     st_in = T_PASS;
                  end
                  REQ_READ: begin
                     rd_ok_in = in_range;
                     st_in = T_READ;
                  end
                  default: begin
                     st_in = T_IDLE;
                  end
               endcase
            end
         end
         T_READ: begin
            rsp_valid_in = 1'b1;
            rsp_sample_in = rd_ok_ff ? coef_rd_ff : '0;
            rsp_done_in = 1'b0;
            st_in = T_IDLE;
         end
         T_PASS: begin
            cnt_in = '0;
            case (pass_ff)
               PASS_ROWL: begin
                  plo_in = lv_ll;
                  phi_in = lv_b;
                  pd_in  = '0;
               end
               PASS_ROWH: begin
                  plo_in = lv_lh;
                  phi_in = lv_hh;
                  pd_in  = lv_hrow;
               end
               default: begin
                  plo_in = '0;
                  phi_in = lv_hrow;
                  pd_in  = lv_b;
               end
            endcase
            st_in = T_LINE;
         end
         T_LINE: begin
            ctl.start = 1'b1;
            st_in = T_WAIT;
         end
         T_WAIT: begin
            coef_we = eng_we && is_col;
            scr_we  = eng_we && !is_col;
            if (stat.done) begin
               if (cnt_ff + CW'(1) < cnt_lim) begin
                  cnt_in = cnt_ff + CW'(1);
                  plo_in = plo_ff + inc_lo;
                  phi_in = phi_ff + inc_hi;
                  pd_in  = pd_ff + inc_d;
                  st_in = T_LINE;
               end else begin
                  case (pass_ff)
                     PASS_ROWL: begin
                        pass_in = PASS_ROWH;
                        st_in = T_PASS;
                     end
                     PASS_ROWH: begin
                        pass_in = PASS_COL;
                        st_in = T_PASS;
                     end
                     default: begin
                        if (lvl_ff == LVL_ONE) begin
                           rsp_valid_in = 1'b1;
                           rsp_sample_in = '0;
                           rsp_done_in = 1'b1;
                           st_in = T_IDLE;
                        end else begin
                           lvl_in = lvl_ff - LVL_ONE;
                           pass_in = PASS_ROWL;
                           st_in = T_PASS;
                        end
                     end
                  endcase
               end
            end
         end
         default: begin
            st_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= T_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         lvl_ff       <= LVL_THREE;
         pass_ff      <= PASS_ROWL;
      end else begin
         st_ff        <= st_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         lvl_ff       <= lvl_in;
         pass_ff      <= pass_in;
      end
      cnt_ff        <= cnt_in;
      plo_ff        <= plo_in;
      phi_ff        <= phi_in;
      pd_ff         <= pd_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_done_ff   <= rsp_done_in;
      rd_ok_ff      <= rd_ok_in;
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_wa] <= coef_wd;
      end
      coef_rd_ff <= coef_mem[coef_ra];
   end

   always_ff @(posedge clock) begin
      if (scr_we) begin
         scr_mem[scr_wa] <= scr_wd;
      end
      scr_rd_ff <= scr_mem[scr_ra];
   end

`ifndef NO_ASSERTIONS
   a_ready_engine_idle : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !stat.busy)
      else $error("word taken while line engine busy");

   a_start_when_idle : assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !stat.busy)
      else $error("line start while engine busy");

   a_done_sample_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_sample == '0))
      else $error("run response carries nonzero sample");

   a_run_rsp_after_line : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid) && rsp_done_res) |-> $past(stat.done))
      else $error("run response without final line done");
`endif

endmodule

// ===== hdl/tidwt_alu.sv =====
// shared lifting unit: optional truncating halving of a sum, add, saturate
module tidwt_alu import tidwt_pkg::*; (
   input  opnd_type   a_in,
   input  opnd_type   b_in,
   input  opnd_type   c_in,
   input  logic       halve,
   output sample_type y_out
);

   logic signed [DATA_W+1:0] sum_ab;
   logic signed [DATA_W+1:0] half_ab;
   logic signed [DATA_W+1:0] sel_ab;
   logic signed [DATA_W+2:0] total;

   always_comb begin
      sum_ab  = (DATA_W+2)'(a_in) + (DATA_W+2)'(b_in);
      half_ab = (sum_ab + $signed({{(DATA_W+1){1'b0}}, sum_ab[DATA_W+1]})) >>> 1;
      sel_ab  = halve ? half_ab : sum_ab;
      total   = (DATA_W+3)'(sel_ab) + (DATA_W+3)'(c_in);
      if (total[DATA_W+2:DATA_W-1] == '0 || total[DATA_W+2:DATA_W-1] == '1) begin
         y_out = total[DATA_W-1:0];
      end else if (total[DATA_W+2]) begin
         y_out = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         y_out = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

endmodule

// ===== hdl/tidwt_line.sv =====
// one inverse lifting line: sequencer around the shared lifting unit
module tidwt_line import tidwt_pkg::*; #(
   parameter int AW = 12,
   parameter int CW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  line_ctl_type  ctl,
   input  logic [AW-1:0] cfg_lo,
   input  logic [AW-1:0] cfg_hi,
   input  logic [AW-1:0] cfg_d,
   input  logic [AW-1:0] cfg_stride,
   input  logic [CW-1:0] cfg_nh,
   input  sample_type    rd_data,
   output logic [AW-1:0] rd_addr,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output sample_type    wr_data,
   output line_stat_type stat
);

   typedef enum logic [16:0] {
      L_IDLE = 17'h00001,
      L_RH0  = 17'h00002,
      L_RL0  = 17'h00004,
      L_X0   = 17'h00008,
      L_RH1  = 17'h00010,
      L_RL1  = 17'h00020,
      L_X2   = 17'h00040,
      L_W0   = 17'h00080,
      L_W1   = 17'h00100,
      L_TA   = 17'h00200,
      L_TB   = 17'h00400,
      L_TRD  = 17'h00800,
      L_TXN  = 17'h01000,
      L_TW0  = 17'h02000,
      L_TW1  = 17'h04000,
      L_TW2  = 17'h08000,
      L_TW3  = 17'h10000
   } lstate_type;

   lstate_type    st_ff, st_in;
   logic [AW-1:0] lp_ff, lp_in, hp_ff, hp_in, dp_ff, dp_in;
   logic [CW-1:0] j_ff, j_in;
   sample_type    h0_ff, h0_in, h1_ff, h1_in, x0_ff, x0_in;
   sample_type    x1_ff, x1_in, x2_ff, x2_in, xn_ff, xn_in;
   logic          done_ff, done_in;

   opnd_type   a_op, b_op, c_op, neg_h0, neg_h1, two_h0, rd_ext;
   logic       halve;
   sample_type alu_y;
   tail_type   tail_go;

   tidwt_alu u_alu (
      .a_in  (a_op),
      .b_in  (b_op),
      .c_in  (c_op),
      .halve (halve),
      .y_out (alu_y)
   );

   always_comb begin
      neg_h0 = -opnd_type'(h0_ff);
      neg_h1 = -opnd_type'(h1_ff);
      two_h0 = opnd_type'(h0_ff) <<< 1;
      rd_ext = opnd_type'(rd_data);
      tail_go = ctl.tail;

      a_op = '0;
      b_op = '0;
      c_op = '0;
      halve = 1'b0;

      st_in = st_ff;
      lp_in = lp_ff;
      hp_in = hp_ff;
      dp_in = dp_ff;
      j_in  = j_ff;
      h0_in = h0_ff;
      h1_in = h1_ff;
      x0_in = x0_ff;
      x1_in = x1_ff;
      x2_in = x2_ff;
      xn_in = xn_ff;
      done_in = 1'b0;
      rd_addr = hp_ff;
      wr_en   = 1'b0;
      wr_addr = dp_ff;
      wr_data = x0_ff;

      case (st_ff)
         L_IDLE: begin
            if (ctl.start) begin
               lp_in = cfg_lo;
               hp_in = cfg_hi;
               dp_in = cfg_d;
               st_in = L_RH0;
            end
         end
         L_RH0: begin
            rd_addr = hp_ff;
            st_in = L_RL0;
         end
         L_RL0: begin
            rd_addr = lp_ff;
            h0_in = rd_data;
            st_in = L_X0;
         end
         L_X0: begin
            a_op = rd_ext;
            c_op = neg_h0;
            x0_in = alu_y;
            x2_in = alu_y;
            j_in = CW'(1);
            if (cfg_nh > CW'(1)) begin
               st_in = L_RH1;
            end else if (tail_go == TAIL_TWO) begin
               st_in = L_TA;
            end else begin
               st_in = L_TRD;
            end
         end
         L_RH1: begin
            rd_addr = hp_ff + cfg_stride;
            hp_in = hp_ff + cfg_stride;
            st_in = L_RL1;
         end
         L_RL1: begin
            rd_addr = lp_ff + cfg_stride;
            lp_in = lp_ff + cfg_stride;
            h1_in = rd_data;
            st_in = L_X2;
         end
         L_X2: begin
            a_op = neg_h0;
            b_op = neg_h1;
            halve = 1'b1;
            c_op = rd_ext;
            x2_in = alu_y;
            st_in = L_W0;
         end
         L_W0: begin
            wr_en = 1'b1;
            wr_data = x0_ff;
            dp_in = dp_ff + cfg_stride;
            a_op = opnd_type'(x0_ff);
            b_op = opnd_type'(x2_ff);
            halve = 1'b1;
            c_op = two_h0;
            x1_in = alu_y;
            st_in = L_W1;
         end
         L_W1: begin
            wr_en = 1'b1;
            wr_data = x1_ff;
            dp_in = dp_ff + cfg_stride;
            x0_in = x2_ff;
            h0_in = h1_ff;
            j_in = j_ff + CW'(1);
            if (j_ff + CW'(1) < cfg_nh) begin
               st_in = L_RH1;
            end else if (tail_go == TAIL_TWO) begin
               st_in = L_TA;
            end else begin
               st_in = L_TRD;
            end
         end
         L_TA: begin
            wr_en = 1'b1;
            wr_data = x2_ff;
            dp_in = dp_ff + cfg_stride;
            a_op = opnd_type'(x2_ff);
            c_op = two_h0;
            x1_in = alu_y;
            st_in = L_TB;
         end
         L_TB: begin
            wr_en = 1'b1;
            wr_data = x1_ff;
            done_in = 1'b1;
            st_in = L_IDLE;
         end
         L_TRD: begin
            rd_addr = lp_ff + cfg_stride;
            lp_in = lp_ff + cfg_stride;
            st_in = L_TXN;
         end
         L_TXN: begin
            if (tail_go == TAIL_THREE) begin
               a_op = rd_ext;
               c_op = neg_h0;
            end else begin
               a_op = neg_h0;
               halve = 1'b1;
               c_op = rd_ext;
            end
            xn_in = alu_y;
            st_in = L_TW0;
         end
         L_TW0: begin
            wr_en = 1'b1;
            wr_data = x2_ff;
            dp_in = dp_ff + cfg_stride;
            a_op = opnd_type'(xn_ff);
            b_op = opnd_type'(x2_ff);
            halve = 1'b1;
            c_op = two_h0;
            x1_in = alu_y;
            st_in = L_TW1;
         end
         L_TW1: begin
            wr_en = 1'b1;
            wr_data = x1_ff;
            dp_in = dp_ff + cfg_stride;
            st_in = L_TW2;
         end
         L_TW2: begin
            wr_en = 1'b1;
            wr_data = xn_ff;
            dp_in = dp_ff + cfg_stride;
            rd_addr = lp_ff + cfg_stride;
            if (tail_go == TAIL_FOUR) begin
               st_in = L_TW3;
            end else begin
               done_in = 1'b1;
               st_in = L_IDLE;
            end
         end
         L_TW3: begin
            a_op = opnd_type'(xn_ff);
            b_op = rd_ext;
            halve = 1'b1;
            wr_en = 1'b1;
            wr_data = alu_y;
            done_in = 1'b1;
            st_in = L_IDLE;
         end
         default: begin
            st_in = L_IDLE;
         end
      endcase

      stat.busy = (st_ff != L_IDLE);
      stat.done = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= L_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      lp_ff <= lp_in;
      hp_ff <= hp_in;
      dp_ff <= dp_in;
      j_ff  <= j_in;
      h0_ff <= h0_in;
      h1_ff <= h1_in;
      x0_ff <= x0_in;
      x1_ff <= x1_in;
      x2_ff <= x2_in;
      xn_ff <= xn_in;
   end

endmodule
